/* rtl/core/imdl_pkg.sv */
// Shared constants, types and control struct for the modulated delay line.
`timescale 1ns / 1ps
`default_nettype none
package imdl_pkg;

  // Ring and sample geometry
  localparam int unsigned DEPTH    = 65536;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned FRAC_W   = 8;

  // Delay time and rate arithmetic
  localparam int unsigned DT_W     = 24;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned PROD_W   = DT_W + RATE_W;
  localparam int unsigned DSHIFT   = DT_W - FRAC_W;
  localparam int unsigned D_W      = PROD_W - DSHIFT;
  localparam int unsigned POS_W    = ADDR_W + FRAC_W;
  localparam int unsigned CMP_W    = (D_W > POS_W) ? D_W : POS_W;
  localparam int unsigned WT_W     = FRAC_W + 1;
  localparam int unsigned MUL_W    = SAMPLE_W + WT_W + 1;
  localparam int unsigned SUM_W    = MUL_W + 1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [POS_W-1:0]  DELAY_MAX  = POS_W'((DEPTH - 2) * (2 ** FRAC_W));
  localparam logic [WT_W-1:0]   WEIGHT_ONE = WT_W'(2 ** FRAC_W);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ADDR = 6'b000010,
    ST_RDA  = 6'b000100,
    ST_RDB  = 6'b001000,
    ST_MIX  = 6'b010000,
    ST_DONE = 6'b100000
  } imdl_state_e;

  // Step controls from the sequencer to each channel
  typedef struct packed {
    logic              wr;
    logic              calc;
    logic              rd_a;
    logic              rd_b;
    logic              mix;
    logic              wrapped;
    logic [ADDR_W-1:0] wp;
  } imdl_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/imdl_in_if.sv */
// Input frame channel: two samples and two delay times.
`timescale 1ns / 1ps
`default_nettype none
interface imdl_in_if
  import imdl_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic        [DT_W-1:0]     left_delay_time;
  logic        [DT_W-1:0]     right_delay_time;

  modport source (output valid, left_sample, right_sample, left_delay_time,
                  right_delay_time, input ready);
  modport sink   (input valid, left_sample, right_sample, left_delay_time,
                  right_delay_time, output ready);
endinterface
`default_nettype wire

/* rtl/core/imdl_out_if.sv */
// Result channel: interpolated left and right samples.
`timescale 1ns / 1ps
`default_nettype none
interface imdl_out_if
  import imdl_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

/* rtl/core/imdl_cfg_if.sv */
// Configuration write channel carrying the sample rate.
`timescale 1ns / 1ps
`default_nettype none
interface imdl_cfg_if
  import imdl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] sample_rate;

  modport source (output valid, sample_rate, input ready);
  modport sink   (input valid, sample_rate, output ready);
endinterface
`default_nettype wire

/* rtl/core/imdl_chan.sv */
// One channel: history ring memory, read position, and linear interpolation.
`timescale 1ns / 1ps
`default_nettype none
module imdl_chan
  import imdl_pkg::*;
(
  input  wire                        clk_i,
  input  wire imdl_ctrl_t            ctrl_i,
  input  wire        [RATE_W-1:0]    rate_i,
  input  wire signed [SAMPLE_W-1:0]  sample_i,
  input  wire        [DT_W-1:0]      delay_time_i,
  output logic signed [SAMPLE_W-1:0] res_o
);

  logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic        [ADDR_W-1:0]   rd_addr;
  logic                       rd_en;

  logic        [PROD_W-1:0]   prod_q;
  logic        [D_W-1:0]      dly;
  logic        [POS_W-1:0]    dly_sat;
  logic        [POS_W-1:0]    pos;
  logic        [ADDR_W-1:0]   a_q;
  logic        [ADDR_W-1:0]   b;
  logic        [FRAC_W-1:0]   frac_q;
  logic                       valid_a_q;
  logic                       valid_b_q;
  logic signed [SAMPLE_W-1:0] ha_q;
  logic signed [SAMPLE_W-1:0] ha;
  logic signed [SAMPLE_W-1:0] hb;
  logic        [WT_W-1:0]     wa;
  logic signed [MUL_W-1:0]    pa_q;
  logic signed [MUL_W-1:0]    pb_q;
  logic signed [SUM_W-1:0]    sum;

  // Ring memory: write the new sample at accept, one read per step
  assign rd_en   = ctrl_i.rd_a | ctrl_i.rd_b;
  assign rd_addr = ctrl_i.rd_a ? a_q : b;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[ctrl_i.wp] <= sample_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Delay in samples with fraction, saturated below the ring size
  assign dly     = prod_q[PROD_W-1:DSHIFT];
  assign dly_sat = (CMP_W'(dly) > CMP_W'(DELAY_MAX)) ? DELAY_MAX : dly[POS_W-1:0];
  assign pos     = {ctrl_i.wp, {FRAC_W{1'b0}}} - dly_sat;
  assign b       = a_q + ADDR_W'(1);

  // Entries past the fill point still read as zero
  assign ha = valid_a_q ? rd_q : '0;
  assign hb = valid_b_q ? rd_q : '0;
  assign wa = WEIGHT_ONE - WT_W'(frac_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      prod_q <= PROD_W'(delay_time_i) * PROD_W'(rate_i);
    end
    if (ctrl_i.calc) begin
      a_q    <= pos[POS_W-1:FRAC_W];
      frac_q <= pos[FRAC_W-1:0];
    end
    if (ctrl_i.rd_a) begin
      valid_a_q <= ctrl_i.wrapped | (a_q <= ctrl_i.wp);
    end
    if (ctrl_i.rd_b) begin
      valid_b_q <= ctrl_i.wrapped | (b <= ctrl_i.wp);
      ha_q      <= ha;
    end
    if (ctrl_i.mix) begin
      pa_q <= MUL_W'(ha_q) * $signed({1'b0, wa});
      pb_q <= MUL_W'(hb) * $signed({1'b0, WT_W'(frac_q)});
    end
  end

  // Blend and round toward minus infinity
  assign sum   = SUM_W'(pa_q) + SUM_W'(pb_q);
  assign res_o = sum[FRAC_W +: SAMPLE_W];

endmodule
`default_nettype wire

/* rtl/core/interpolated_modulated_delay_line.sv */
// Stereo modulated delay line with linearly interpolated fractional reads.
// An accepted item steps through the address, read A, read B, mix and done states;
//   its result loads the output register once that is free. No new item is accepted
//   before then; each channel's single memory port reads sample, then neighbor.
// Reset: write pointer zero, sample rate 48000; history entries not yet written
//   read as zero through fill tracking, so no clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none
module interpolated_modulated_delay_line
  import imdl_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  imdl_in_if.sink   in_i,
  imdl_out_if.source out_o,
  imdl_cfg_if.sink  cfg_i
);

  imdl_state_e                state_q, state_d;
  logic        [ADDR_W-1:0]   wp_q;
  logic                       wrapped_q;
  logic        [RATE_W-1:0]   rate_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] left_out_q;
  logic signed [SAMPLE_W-1:0] right_out_q;
  logic signed [SAMPLE_W-1:0] left_res;
  logic signed [SAMPLE_W-1:0] right_res;
  logic                       in_acc;
  logic                       out_free;
  logic                       finish;
  imdl_ctrl_t                 ctrl;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_free    = ~out_valid_q | out_o.ready;
  assign finish      = (state_q == ST_DONE) & out_free;
  assign cfg_i.ready = 1'b1;

  // Step the sequencer through one item
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_RDA;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_MIX;
      ST_MIX:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive channel step controls
  always_comb begin
    ctrl.wr      = in_acc;
    ctrl.calc    = (state_q == ST_ADDR);
    ctrl.rd_a    = (state_q == ST_RDA);
    ctrl.rd_b    = (state_q == ST_RDB);
    ctrl.mix     = (state_q == ST_MIX);
    ctrl.wrapped = wrapped_q;
    ctrl.wp      = wp_q;
  end

  // Control registers: state, write pointer, fill flag, rate, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      rate_q      <= RATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        rate_q <= cfg_i.sample_rate;
      end
      if (finish) begin
        wp_q <= wp_q + ADDR_W'(1);
        if (wp_q == ADDR_LAST) begin
          wrapped_q <= 1'b1;
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result item when the output register frees up
  always_ff @(posedge clk_i) begin
    if (finish) begin
      left_out_q  <= left_res;
      right_out_q <= right_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = left_out_q;
  assign out_o.right_out = right_out_q;

  imdl_chan u_left (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .rate_i       (rate_q),
    .sample_i     (in_i.left_sample),
    .delay_time_i (in_i.left_delay_time),
    .res_o        (left_res)
  );

  imdl_chan u_right (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .rate_i       (rate_q),
    .sample_i     (in_i.right_sample),
    .delay_time_i (in_i.right_delay_time),
    .res_o        (right_res)
  );

endmodule
`default_nettype wire

/* rtl/core/imdl_checker.sv */
// Port-level checks for the delay line, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module imdl_checker
  import imdl_pkg::*;
(
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_ready_i,
  input wire                       out_valid_i,
  input wire                       out_ready_i,
  input wire signed [SAMPLE_W-1:0] left_out_i,
  input wire signed [SAMPLE_W-1:0] right_out_i
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(left_out_i) && $stable(right_out_i))
    else $error("stalled result item changed");

  // One item in flight: no new item right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while another is in flight");

  // A result cannot appear the cycle after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result item appeared too early");

endmodule

bind interpolated_modulated_delay_line imdl_checker u_imdl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_out_i  (out_o.left_out),
  .right_out_i (out_o.right_out)
);
`default_nettype wire
